### sv/b64sd_pkg.sv
// shared types, constants and character class for the base64 section detector
`default_nettype none

package b64sd_pkg;

  // detector status codes, also the result status field
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_INFO  = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  // header phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // byte history patterns
  localparam logic [31:0] KEYWORD_TAIL  = 32'h73653634; // "se64"
  localparam logic [23:0] KEYWORD_LOWER = 24'h206261;   // " ba"
  localparam logic [23:0] KEYWORD_UPPER = 24'h204261;   // " Ba"
  localparam logic [31:0] BLANK_LINE    = 32'h0D0A0D0A;
  localparam logic [15:0] LINE_END      = 16'h0D0A;
  localparam logic [23:0] PAD_ONE       = 24'h3D0D0A;
  localparam logic [31:0] PAD_TWO       = 32'h3D3D0D0A;
  localparam logic [7:0]  PAD_CHAR      = 8'h3D;

  // length limits
  localparam int HEADER_MAX = 192;
  localparam int BODY_MIN   = 512;
  localparam int LINE_MIN   = 4;
  localparam int LINE_MAX   = 255;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] section_start;
    logic [31:0] section_end;
  } b64sd_result_t;

  // letters, digits, '+', '/', CR and LF
  function automatic logic b64_char(input logic [7:0] c);
    logic ok;
    ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
         (c >= 8'h61 && c <= 8'h7A) || c == 8'h2B || c == 8'h2F ||
         c == 8'h0A || c == 8'h0D;
    return ok;
  endfunction

endpackage

`default_nettype wire

### sv/base64_section_detector.sv
// base64 section detector: input register, scan core and result register
//
// Usage:
//   in_*  channel: one transaction per stream byte, data byte and absolute
//         position. out_* channel: one transaction per input byte, carrying
//         status (0 none, 1 header, 2 body, 3 found) and, when status is 3,
//         the first and last body positions.
//   cfg_* channel: writes the exclusive upper bound on body length; always
//         ready; user must write only while the block is idle, not enforced.
// Timing:
//   a byte taken into the input register is scanned from there and its
//   result is registered in the result register when the byte advances.
//   Throughput is one byte per cycle while out_ready is high, set by the
//   single scan stage.
// Reset (rst_n low, synchronous) empties both registers, clears the byte
//   history and the detector state, and sets the length bound to all ones.
// Stall: while out_ready is low the result holds and the input register
//   still takes one more byte; then in_ready drops until the result leaves.
`default_nettype none

module base64_section_detector import b64sd_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [31:0] in_byte_position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_section_start,
  output logic [31:0]      out_section_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_max_section_length
);

  localparam int WideBits = POSITION_BITS + 32;

  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  logic [POSITION_BITS-1:0] in_pos_r;
  logic                     out_valid_r;
  b64sd_result_t            out_r;
  logic [31:0]              max_len_r;
  logic                     advance, in_fire;
  logic [WideBits-1:0]      pos_wide;
  b64sd_result_t            core_res;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign pos_wide  = WideBits'(in_byte_position);

  b64sd_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .data_byte (in_byte_r),
    .pos       (in_pos_r),
    .max_len   (max_len_r),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= '1;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_section_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_data_byte;
      in_pos_r  <= pos_wide[POSITION_BITS-1:0];
    end
    if (advance) begin
      out_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_section_start = out_r.section_start;
  assign out_section_end   = out_r.section_end;

endmodule

`default_nettype wire

### sv/b64sd_core.sv
// detector state registers and per-byte scan logic
`default_nettype none

module b64sd_core import b64sd_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step_en,
  input  wire logic [7:0]               data_byte,
  input  wire logic [POSITION_BITS-1:0] pos,
  input  wire logic [31:0]              max_len,
  output b64sd_result_t                 res
);

  localparam int WideBits = POSITION_BITS + 32;

  logic [31:0]              recent_low_r, recent_low_nxt;
  logic [23:0]              recent_high_r, recent_high_nxt;
  logic [1:0]               detect_state_r, detect_state_nxt;
  logic [1:0]               header_phase_r, header_phase_nxt;
  logic [POSITION_BITS-1:0] keyword_pos_r, keyword_pos_nxt;
  logic [POSITION_BITS-1:0] body_begin_r, body_begin_nxt;
  logic [POSITION_BITS-1:0] first_len_r, first_len_nxt;
  logic [POSITION_BITS-1:0] last_nl_r, last_nl_nxt;
  logic [POSITION_BITS-1:0] found_start_r, found_start_nxt;
  logic [POSITION_BITS-1:0] found_end_r, found_end_nxt;

  logic                     keyword_hit, is_blank, is_crlf, is_pad;
  logic [POSITION_BITS-1:0] pos_m1, pos_m3, pos_p1, pos_p2;
  logic [POSITION_BITS-1:0] header_len, line_len, run_len, len_m1, len_m3;
  logic                     fit_m1, fit_m3;
  logic [WideBits-1:0]      max_wide, start_wide, end_wide;

  assign recent_low_nxt  = {recent_low_r[23:0], data_byte};
  assign recent_high_nxt = {recent_high_r[15:0], recent_low_r[31:24]};

  assign keyword_hit = recent_low_nxt == KEYWORD_TAIL &&
                       (recent_high_nxt == KEYWORD_LOWER || recent_high_nxt == KEYWORD_UPPER);
  assign is_blank = recent_low_nxt == BLANK_LINE;
  assign is_crlf  = recent_low_nxt[15:0] == LINE_END;
  assign is_pad   = recent_low_nxt[23:0] == PAD_ONE || recent_low_nxt == PAD_TWO;

  assign pos_m1 = pos - POSITION_BITS'(1);
  assign pos_m3 = pos - POSITION_BITS'(3);
  assign pos_p1 = pos + POSITION_BITS'(1);
  assign pos_p2 = pos + POSITION_BITS'(2);

  assign header_len = pos_p1 - keyword_pos_r;
  assign line_len   = pos - body_begin_r;
  assign run_len    = pos - last_nl_r + POSITION_BITS'(1);
  assign len_m1     = pos_m1 - body_begin_r;
  assign len_m3     = pos_m3 - body_begin_r;

  assign max_wide = WideBits'(max_len);
  assign fit_m1 = len_m1 > POSITION_BITS'(BODY_MIN) && WideBits'(len_m1) < max_wide;
  assign fit_m3 = len_m3 > POSITION_BITS'(BODY_MIN) && WideBits'(len_m3) < max_wide;

  always_comb begin
    detect_state_nxt = detect_state_r;
    header_phase_nxt = header_phase_r;
    keyword_pos_nxt  = keyword_pos_r;
    body_begin_nxt   = body_begin_r;
    first_len_nxt    = first_len_r;
    last_nl_nxt      = last_nl_r;
    found_start_nxt  = found_start_r;
    found_end_nxt    = found_end_r;
    if (detect_state_r == ST_NONE) begin
      if (keyword_hit) begin
        detect_state_nxt = ST_START;
        header_phase_nxt = PH_HEADER;
        keyword_pos_nxt  = pos - POSITION_BITS'(6);
        body_begin_nxt   = '0;
      end
    end else if (detect_state_r == ST_START || detect_state_r == ST_INFO) begin
      if (header_phase_r == PH_HEADER && is_blank) begin
        header_phase_nxt = PH_BODY;
        body_begin_nxt   = pos_p1;
        if (header_len > POSITION_BITS'(HEADER_MAX)) begin
          header_phase_nxt = PH_IDLE;
          detect_state_nxt = ST_NONE;
        end
      end else if (header_phase_r == PH_BODY && is_crlf && first_len_r == '0) begin
        first_len_nxt = line_len;
        last_nl_nxt   = pos_p2;
        if (line_len <= POSITION_BITS'(LINE_MIN) || line_len > POSITION_BITS'(LINE_MAX)) begin
          header_phase_nxt = PH_IDLE;
          detect_state_nxt = ST_NONE;
        end
      end else if (header_phase_r == PH_BODY && is_crlf && !is_pad) begin
        last_nl_nxt = pos_p2;
        if (run_len < first_len_r && !is_blank) begin
          // short line closes the body
          if (fit_m1) begin
            found_start_nxt  = body_begin_r;
            found_end_nxt    = pos_m1;
            detect_state_nxt = ST_END;
            last_nl_nxt      = last_nl_r;
          end
        end else if (is_blank) begin
          if (fit_m3) begin
            found_start_nxt  = body_begin_r;
            found_end_nxt    = pos_m3;
            detect_state_nxt = ST_END;
            last_nl_nxt      = last_nl_r;
          end else begin
            detect_state_nxt = ST_NONE;
          end
        end
      end else if (header_phase_r == PH_BODY && is_pad) begin
        if (fit_m1) begin
          found_start_nxt  = body_begin_r;
          found_end_nxt    = pos_m1;
          detect_state_nxt = ST_END;
        end else begin
          detect_state_nxt = ST_NONE;
        end
      end else if (header_phase_r == PH_BODY && (b64_char(data_byte) || data_byte == PAD_CHAR)) begin
        detect_state_nxt = ST_INFO;
      end else if (header_phase_r == PH_BODY) begin
        detect_state_nxt = ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_low_r   <= '0;
      recent_high_r  <= '0;
      detect_state_r <= ST_NONE;
      header_phase_r <= PH_IDLE;
      keyword_pos_r  <= '0;
      body_begin_r   <= '0;
      first_len_r    <= '0;
      last_nl_r      <= '0;
      found_start_r  <= '0;
      found_end_r    <= '0;
    end else if (step_en) begin
      recent_low_r   <= recent_low_nxt;
      recent_high_r  <= recent_high_nxt;
      detect_state_r <= detect_state_nxt;
      header_phase_r <= header_phase_nxt;
      keyword_pos_r  <= keyword_pos_nxt;
      body_begin_r   <= body_begin_nxt;
      first_len_r    <= first_len_nxt;
      last_nl_r      <= last_nl_nxt;
      found_start_r  <= found_start_nxt;
      found_end_r    <= found_end_nxt;
    end
  end

  assign start_wide = WideBits'(found_start_nxt);
  assign end_wide   = WideBits'(found_end_nxt);

  always_comb begin
    res.status        = detect_state_nxt;
    res.section_start = '0;
    res.section_end   = '0;
    if (detect_state_nxt == ST_END) begin
      res.section_start = start_wide[31:0];
      res.section_end   = end_wide[31:0];
    end
  end

endmodule

`default_nettype wire
